### sv/bic_pkg.sv
// Shared types and constants for the binary image centroid block.
// No dependencies; imported by every module of the block.
package bic_pkg;

    // Default largest frame dimension
    localparam int MAX_DIM_DEF = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;
    localparam logic [CFG_W-1:0]     DIM_RESET      = 11'd1024;

    // Stream payloads
    localparam int CENTER_W    = 10;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Controller to datapath commands
    typedef struct packed {
        logic accum;   // add the accepted pixel and advance the position
        logic snap;    // frame ends: load divider, clear accumulators
        logic step;    // one divider iteration
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic frame_end;   // current position is the last pixel of the frame
        logic empty_next;  // no set pixel once the current pixel is counted
        logic div_last;    // divider is on its final iteration
    } t_dp_stat;

endpackage

### sv/bic_dp.sv
// Accumulation datapath: frame position tracking and first-moment sums.
// Depends on bic_pkg.
module bic_dp
    import bic_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CFG_W-1:0]             i_frame_rows,
    input  logic [CFG_W-1:0]             i_frame_cols,
    input  t_dp_cmd                      i_cmd,
    input  logic                         i_pixel_on,
    output logic                         o_frame_end,
    output logic                         o_empty_next,
    output logic [3*$clog2(MAX_DIM)-1:0] o_row_sum_next,
    output logic [3*$clog2(MAX_DIM)-1:0] o_col_sum_next,
    output logic [2*$clog2(MAX_DIM):0]   o_count_next
);

    localparam int PW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int SW = 3 * PW;
    localparam int CW = 2 * PW + 1;

    logic [PW-1:0] r_row, n_row;
    logic [PW-1:0] r_col, n_col;
    logic [SW-1:0] r_row_sum, n_row_sum;
    logic [SW-1:0] r_col_sum, n_col_sum;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] rows, cols;
    logic          col_more, row_more;

    // Zero acts as one, anything above MAX_DIM as MAX_DIM
    always_comb begin
        if (i_frame_rows == '0) begin
            rows = DW'(1);
        end else if (32'(i_frame_rows) > 32'(MAX_DIM)) begin
            rows = DW'(MAX_DIM);
        end else begin
            rows = DW'(i_frame_rows);
        end
        if (i_frame_cols == '0) begin
            cols = DW'(1);
        end else if (32'(i_frame_cols) > 32'(MAX_DIM)) begin
            cols = DW'(MAX_DIM);
        end else begin
            cols = DW'(i_frame_cols);
        end
    end

    assign col_more    = (32'(r_col) + 32'd1) < 32'(cols);
    assign row_more    = (32'(r_row) + 32'd1) < 32'(rows);
    assign o_frame_end = !col_more && !row_more;

    assign n_row_sum = i_pixel_on ? r_row_sum + SW'(r_row) : r_row_sum;
    assign n_col_sum = i_pixel_on ? r_col_sum + SW'(r_col) : r_col_sum;
    assign n_count   = i_pixel_on ? r_count + CW'(1) : r_count;

    assign o_row_sum_next = n_row_sum;
    assign o_col_sum_next = n_col_sum;
    assign o_count_next   = n_count;
    assign o_empty_next   = (n_count == '0);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_more) begin
            n_col = r_col + PW'(1);
        end else begin
            n_col = '0;
            if (row_more) begin
                n_row = r_row + PW'(1);
            end else begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_count   <= '0;
        end else if (i_cmd.accum) begin
            r_row <= n_row;
            r_col <= n_col;
            if (i_cmd.snap) begin
                r_row_sum <= '0;
                r_col_sum <= '0;
                r_count   <= '0;
            end else begin
                r_row_sum <= n_row_sum;
                r_col_sum <= n_col_sum;
                r_count   <= n_count;
            end
        end
    end

endmodule

### sv/bic_div.sv
// Iterative divider: both index sums over the shared set-pixel count,
// one quotient bit per cycle. Depends on bic_pkg.
module bic_div
    import bic_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic                         i_empty,
    input  logic [3*$clog2(MAX_DIM)-1:0] i_row_sum,
    input  logic [3*$clog2(MAX_DIM)-1:0] i_col_sum,
    input  logic [2*$clog2(MAX_DIM):0]   i_count,
    output logic                         o_last,
    output logic [$clog2(MAX_DIM)-1:0]   o_q_row,
    output logic [$clog2(MAX_DIM)-1:0]   o_q_col,
    output logic                         o_empty
);

    localparam int PW    = $clog2(MAX_DIM);
    localparam int SW    = 3 * PW;
    localparam int CNT_W = $clog2(PW + 1);

    logic [SW-1:0]    r_rem_row, r_rem_col, r_den;
    logic [PW-1:0]    r_q_row, r_q_col;
    logic [CNT_W-1:0] r_cnt;
    logic             r_empty;
    logic             ge_row, ge_col;
    logic [PW:0]      q_row_sh, q_col_sh;

    // Quotients stay below MAX_DIM, so the search starts at bit PW-1
    assign ge_row   = r_rem_row >= r_den;
    assign ge_col   = r_rem_col >= r_den;
    assign q_row_sh = {r_q_row, ge_row};
    assign q_col_sh = {r_q_col, ge_col};
    assign o_last   = (r_cnt == CNT_W'(1));
    assign o_q_row  = r_q_row;
    assign o_q_col  = r_q_col;
    assign o_empty  = r_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_empty <= 1'b0;
        end else if (i_cmd.snap) begin
            r_cnt   <= i_empty ? '0 : CNT_W'(PW);
            r_empty <= i_empty;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_rem_row <= i_row_sum;
            r_rem_col <= i_col_sum;
            r_den     <= SW'(i_count) << (PW - 1);
            r_q_row   <= '0;
            r_q_col   <= '0;
        end else if (i_cmd.step) begin
            if (ge_row) begin
                r_rem_row <= r_rem_row - r_den;
            end
            if (ge_col) begin
                r_rem_col <= r_rem_col - r_den;
            end
            r_q_row <= q_row_sh[PW-1:0];
            r_q_col <= q_col_sh[PW-1:0];
            r_den   <= r_den >> 1;
        end
    end

endmodule

### sv/bic_ctrl.sv
// Controller: pixel acceptance, divider sequencing and result valid.
// Depends on bic_pkg.
module bic_ctrl
    import bic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_ACC = 1'b0;
    localparam logic S_DIV = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    // Hold the last pixel of a frame while the previous result is pending
    assign o_in_ready  = (r_state == S_ACC) && !(r_out_valid && i_stat.frame_end);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_ACC: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accum = 1'b1;
                    if (i_stat.frame_end) begin
                        o_cmd.snap = 1'b1;
                        if (i_stat.empty_next) begin
                            n_out_valid = 1'b1;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_out_valid = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/binary_image_centroid.sv
// Top level of the binary image centroid block.
// Depends on bic_pkg, bic_ctrl, bic_dp and bic_div.
//
// Binary pixels stream in raster order, one per transfer, in bit 0 of the
// slave tdata. Each set pixel adds its row index, column index and one to
// three accumulators; the frame is frame_rows by frame_cols pixels, where a
// value of zero acts as one and a value above MAX_DIM acts as MAX_DIM.
// Pixels are taken at one per clock when the input is not stalled. After the last pixel of a frame the
// block divides both index sums by the set-pixel count with a shared
// restoring divider that yields one quotient bit per cycle, so the input
// stalls through the whole division, from the top quotient bit to the last,
// before the next frame starts; an empty frame skips the division. The
// result is one master transfer per frame with the truncated centroid and
// an empty flag (coordinates zero when empty). The result is held in
// registers until taken; pixels of the next frame keep flowing meanwhile,
// and only the last pixel of that frame waits for the pending result to
// go. Write frame_rows (index 0) and frame_cols (index 1) only while the
// block is idle; other indexes are ignored.
module binary_image_centroid
    import bic_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Pixel stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [0] pixel_on
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [9:0] center_row, [19:10] center_col
    output logic                   o_m_axis_tuser,   // [0] frame_empty
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int PW = $clog2(MAX_DIM);
    localparam int SW = 3 * PW;
    localparam int CW = 2 * PW + 1;

    logic [CFG_W-1:0]       r_frame_rows, r_frame_cols;
    t_dp_cmd                cmd;
    t_dp_stat               stat;
    logic                   frame_end, empty_next, div_last;
    logic [SW-1:0]          row_sum_next, col_sum_next;
    logic [CW-1:0]          count_next;
    logic [PW-1:0]          q_row, q_col;
    logic                   q_empty;
    logic [CENTER_W+PW-1:0] row_ext, col_ext;

    // Configuration registers; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= DIM_RESET;
            r_frame_cols <= DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                REG_FRAME_COLS: r_frame_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign stat.frame_end  = frame_end;
    assign stat.empty_next = empty_next;
    assign stat.div_last   = div_last;

    bic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bic_dp #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_rows   (r_frame_rows),
        .i_frame_cols   (r_frame_cols),
        .i_cmd          (cmd),
        .i_pixel_on     (i_s_axis_tdata[0]),
        .o_frame_end    (frame_end),
        .o_empty_next   (empty_next),
        .o_row_sum_next (row_sum_next),
        .o_col_sum_next (col_sum_next),
        .o_count_next   (count_next)
    );

    bic_div #(.MAX_DIM(MAX_DIM)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_empty   (empty_next),
        .i_row_sum (row_sum_next),
        .i_col_sum (col_sum_next),
        .i_count   (count_next),
        .o_last    (div_last),
        .o_q_row   (q_row),
        .o_q_col   (q_col),
        .o_empty   (q_empty)
    );

    // Quotient registers hold while the result is pending; mask to field width
    assign row_ext = {CENTER_W'(0), q_row};
    assign col_ext = {CENTER_W'(0), q_col};

    assign o_m_axis_tdata = {{(OUT_TDATA_W - 2 * CENTER_W){1'b0}},
                             col_ext[CENTER_W-1:0], row_ext[CENTER_W-1:0]};
    assign o_m_axis_tuser = q_empty;

endmodule

### dv/binary_image_centroid_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_image_centroid: streams binary frames of many
// sizes, predicts each centroid in a small scoreboard class and checks every result.
// Depends on bic_pkg and the binary_image_centroid RTL.
module binary_image_centroid_tb;
    import bic_pkg::*;

    localparam int DIM_LIMIT    = MAX_DIM_DEF;
    // Margin after the results drain, to let the divider go quiet
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 500000;
    // Random small-frame pixels, spread over the three idling phases
    localparam int PIXEL_TARGET = 750;
    // Indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CENTER_W-1:0] row;
        logic [CENTER_W-1:0] col;
        logic                empty;
    } t_centroid;

    // Tracks raster position and first moments, queues the centroid of each frame
    class centroid_scoreboard;
        logic [CFG_W-1:0] rows_reg;
        logic [CFG_W-1:0] cols_reg;
        int unsigned      row_pos;
        int unsigned      col_pos;
        int unsigned      pix_count;
        longint unsigned  row_sum;
        longint unsigned  col_sum;
        t_centroid        centroids_due[$];
        int unsigned      mismatches;
        int unsigned      frames_seen;

        function new();
            rows_reg    = DIM_RESET;
            cols_reg    = DIM_RESET;
            mismatches  = 0;
            frames_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            row_pos   = 0;
            col_pos   = 0;
            pix_count = 0;
            row_sum   = 0;
            col_sum   = 0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FRAME_ROWS: rows_reg = val;
                REG_FRAME_COLS: cols_reg = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return centroids_due.size();
        endfunction

        // Returns 1 when the pixel closes a frame
        function bit note_pixel(bit on);
            int unsigned rows;
            int unsigned cols;
            t_centroid   c;
            rows = clamp_dim(rows_reg);
            cols = clamp_dim(cols_reg);
            if (on) begin
                row_sum   += row_pos;
                col_sum   += col_pos;
                pix_count += 1;
            end
            if (col_pos + 1 < cols) begin
                col_pos += 1;
                return 1'b0;
            end
            col_pos = 0;
            if (row_pos + 1 < rows) begin
                row_pos += 1;
                return 1'b0;
            end
            if (pix_count == 0) begin
                c = '{row: '0, col: '0, empty: 1'b1};
            end else begin
                c.row   = CENTER_W'(row_sum / pix_count);
                c.col   = CENTER_W'(col_sum / pix_count);
                c.empty = 1'b0;
            end
            centroids_due.push_back(c);
            clear_frame();
            return 1'b1;
        endfunction

        task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
            mismatches++;
            $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got_v, want_v);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            t_centroid got;
            t_centroid want;
            got.row   = tdata[CENTER_W-1:0];
            got.col   = tdata[2*CENTER_W-1:CENTER_W];
            got.empty = tuser;
            if (centroids_due.size() == 0) begin
                report_mismatch("result with no frame closed, center_row", got.row, 0);
            end else begin
                want = centroids_due.pop_front();
                frames_seen++;
                if (got.row !== want.row)
                    report_mismatch("center_row", got.row, want.row);
                if (got.col !== want.col)
                    report_mismatch("center_col", got.col, want.col);
                if (got.empty !== want.empty)
                    report_mismatch("frame_empty", got.empty, want.empty);
            end
        endtask
    endclass

    // Clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Block inputs, all known from time zero
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_cfg_ready;

    binary_image_centroid dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [0] pixel_on
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [9:0] center_row, [19:10] center_col
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] frame_empty
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    centroid_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned pixels_sent   = 0;
    int unsigned cfg_writes    = 0;
    int unsigned cycle_count   = 0;
    bit          frame_closed  = 1'b0;

    // Hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check each transfer on the edge that completes it, then
    // pick the stall for the next cycle. Values read here are pre-edge.
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one pixel, idling first at the sender rate, and hold it until taken.
    // Valid stays high on return so back-to-back pixels stream without a gap.
    task automatic push_pixel(input bit on);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, on};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        frame_closed = sb.note_pixel(on);
        pixels_sent++;
    endtask

    // Stream pixels until the frame closes or max_px have gone (0 means no cap).
    // Each pixel is set with probability fill percent, or when it is pixel spot.
    task automatic run_frame(input int fill, input int spot, input int max_px);
        int idx;
        idx = 0;
        do begin
            push_pixel((idx == spot) || ($urandom_range(99) < fill));
            idx++;
        end while (!frame_closed && (max_px == 0 || idx < max_px));
    endtask

    // Drop valid, drain every pending result, then let the divider go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Present one register write and hold it until the transfer completes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic program_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FRAME_COLS, cols);
        cfg_valid <= 1'b0;
    endtask

    // Mostly tiny dimensions, sometimes zero (acts as one), sometimes mid-sized
    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0) return '0;
        if (roll == 1) return CFG_W'($urandom_range(24, 9));
        return CFG_W'($urandom_range(8, 1));
    endfunction

    // One random frame with a random fill pattern; sometimes resize mid-frame
    task automatic random_frame();
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        int               size;
        int               fill;
        int               spot;
        settle();
        if ($urandom_range(9) == 0) begin
            write_reg(($urandom_range(1) != 0) ? REG_SPARE_3 : REG_SPARE_2,
                      CFG_W'($urandom));
        end
        rows = pick_dim();
        cols = pick_dim();
        program_dims(rows, cols);
        size = sb.clamp_dim(rows) * sb.clamp_dim(cols);
        spot = -1;
        case ($urandom_range(3))
            0: fill = 0;
            1: fill = 100;
            2: begin
                fill = 0;
                spot = $urandom_range(size - 1);
            end
            default: fill = $urandom_range(99, 1);
        endcase
        if (size > 1 && $urandom_range(7) == 0) begin
            // Part of the frame, then new dimensions with the positions kept
            run_frame(fill, spot, $urandom_range(size - 1, 1));
            settle();
            program_dims(CFG_W'($urandom_range(8)), CFG_W'($urandom_range(8)));
        end
        run_frame(fill, spot, 0);
    endtask

    initial begin
        int unsigned phase_start;
        sb = new();
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 69;

        // Three pixels into the reset-size frame, then shrink to one row of two:
        // the column is past the new width and the row is the last, so the next
        // pixel closes the frame.
        run_frame(100, -1, 2);
        push_pixel(1'b0);
        settle();
        program_dims(11'd1, 11'd2);
        push_pixel(1'b1);

        // Zero dimensions act as one: an empty frame, then a set single pixel
        settle();
        program_dims('0, '0);
        push_pixel(1'b0);
        push_pixel(1'b1);

        // Full and empty 2x3 frames
        settle();
        program_dims(11'd2, 11'd3);
        run_frame(100, -1, 0);
        run_frame(0, -1, 0);

        // Writes to undecoded indexes must leave the dimensions alone
        settle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, 11'd1);
        cfg_valid <= 1'b0;
        run_frame(50, -1, 0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 2) begin
                // Largest coordinate: a tall column with only the bottom pixel set,
                // height clamped from the top register value
                settle();
                program_dims('1, 11'd1);
                run_frame(0, DIM_LIMIT - 1, 0);
            end
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PIXEL_TARGET / 3) random_frame();
        end

        settle();
        if (sb.pending() != 0)
            sb.report_mismatch("frame results never delivered", sb.pending(), 0);
        $display("Run covered %0d pixels, %0d checked frames, %0d register writes,",
                 pixels_sent, sb.frames_seen, cfg_writes);
        $display("frames from 1x1 to 1024 pixels, empty and full fills, mid-frame resizes.");
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### binary_image_centroid.f
sv/bic_pkg.sv
sv/bic_dp.sv
sv/bic_div.sv
sv/bic_ctrl.sv
sv/binary_image_centroid.sv
dv/binary_image_centroid_tb.sv
